>>> rtl/fpid_pkg.sv
// Shared types, register indexes and constants for the fixed-point PID controller.
package fpid_pkg;

    // Default sample width of measured and setpoint
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 31;
    localparam int SHIFT_W = 5;
    localparam int ACC_W   = 32;
    localparam int DRIVE_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_INCREMENTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP               = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI               = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD               = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_SHIFT       = 3'd6;

    // Register reset values
    localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RST = 5'd8;

    // Request codes
    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Mode codes
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // Controller settings as seen by the datapath
    typedef struct packed {
        logic                      mode_incremental;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0]        out_limit;
        logic [LIMIT_W-1:0]        integral_limit;
        logic [SHIFT_W-1:0]        frac_shift;
    } fpid_cfg_t;

endpackage

>>> rtl/fpid_if.sv
// Handshake channel interfaces: sample input, drive output and register writes.
interface fpid_in_if #(
    parameter int SAMPLE_WIDTH = fpid_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic signed [SAMPLE_WIDTH-1:0] setpoint;

    modport source (output valid, output req_type, output measured, output setpoint,
                    input ready);
    modport sink   (input valid, input req_type, input measured, input setpoint,
                    output ready);
endinterface

interface fpid_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fpid_pkg::DRIVE_W-1:0]   drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface fpid_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fpid_pkg::CFG_IDX_W-1:0]     index;
    logic [fpid_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/fixed_point_pid_controller.sv
// Top level of the fixed-point PID controller: input stage, output stage and handshakes.
//
// Each transaction on din carries a request, a measured sample and a setpoint, and gives
// exactly one drive value on dout. The sample is captured in an input register; once the
// output register is free or being emptied, the error, three 16-bit gain multiplies, the
// arithmetic shifts, the sums and the clamps are evaluated in one pass and written to the
// output register, which drives dout, together with the controller history. One sample is
// taken every cycle while dout keeps up. A clear request zeroes the history and returns 0.
// Registers on cfg are taken at any time and should only be changed while no sample is in
// flight.
module fixed_point_pid_controller #(
    parameter int SAMPLE_WIDTH = fpid_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    fpid_in_if.sink  din,
    fpid_out_if.source dout,
    fpid_cfg_if.sink cfg
);
    import fpid_pkg::*;

    fpid_cfg_t settings;

    // Input stage
    logic                           in_valid_reg;
    logic                           in_req_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_measured_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_setpoint_reg;

    // Output stage
    logic                           out_valid_reg;
    logic signed [DRIVE_W-1:0]      out_drive_reg;
    logic signed [DRIVE_W-1:0]      drive_next;

    logic step_en;

    // A sample moves on when the output register is free or being emptied
    assign step_en   = in_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !in_valid_reg || step_en;

    assign dout.valid = out_valid_reg;
    assign dout.drive = out_drive_reg;

    fpid_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    fpid_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .req_type   (in_req_reg),
        .measured   (in_measured_reg),
        .setpoint   (in_setpoint_reg),
        .settings   (settings),
        .drive_next (drive_next)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (din.ready)
            in_valid_reg <= din.valid;
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            in_req_reg      <= din.req_type;
            in_measured_reg <= din.measured;
            in_setpoint_reg <= din.setpoint;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (step_en)
            out_drive_reg <= drive_next;
    end

endmodule

>>> rtl/fpid_cfg_regs.sv
// Configuration register file of the PID controller.
module fpid_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    fpid_cfg_if.sink             cfg,
    output fpid_pkg::fpid_cfg_t  settings
);
    import fpid_pkg::*;

    fpid_cfg_t settings_reg;
    fpid_cfg_t settings_next;

    assign cfg.ready = 1'b1;
    assign settings  = settings_reg;

    // Decode one register write per transaction; unknown indexes are dropped
    always_comb
    begin
        settings_next = settings_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MODE_INCREMENTAL: settings_next.mode_incremental = cfg.data[0];
                CFG_KP:               settings_next.kp = $signed(cfg.data[GAIN_W-1:0]);
                CFG_KI:               settings_next.ki = $signed(cfg.data[GAIN_W-1:0]);
                CFG_KD:               settings_next.kd = $signed(cfg.data[GAIN_W-1:0]);
                CFG_OUT_LIMIT:        settings_next.out_limit = cfg.data[LIMIT_W-1:0];
                CFG_INTEGRAL_LIMIT:   settings_next.integral_limit = cfg.data[LIMIT_W-1:0];
                CFG_FRAC_SHIFT:       settings_next.frac_shift = cfg.data[SHIFT_W-1:0];
                default:              settings_next = settings_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.mode_incremental <= MODE_POSITIONAL;
            settings_reg.kp               <= '0;
            settings_reg.ki               <= '0;
            settings_reg.kd               <= '0;
            settings_reg.out_limit        <= '0;
            settings_reg.integral_limit   <= '0;
            settings_reg.frac_shift       <= FRAC_SHIFT_RST;
        end
        else
        begin
            settings_reg <= settings_next;
        end
    end

endmodule

>>> rtl/fpid_core.sv
// PID arithmetic and controller history (errors, integral, last drive).
module fpid_core #(
    parameter int SAMPLE_WIDTH = fpid_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step_en,
    input  logic                                 req_type,
    input  logic signed [SAMPLE_WIDTH-1:0]       measured,
    input  logic signed [SAMPLE_WIDTH-1:0]       setpoint,
    input  fpid_pkg::fpid_cfg_t                  settings,
    output logic signed [fpid_pkg::DRIVE_W-1:0]  drive_next
);
    import fpid_pkg::*;

    // Error and its differences, products after the gain multiply
    localparam int EW  = SAMPLE_WIDTH + 1;
    localparam int D2W = SAMPLE_WIDTH + 3;
    localparam int PW  = D2W + GAIN_W;
    localparam int SW  = ((PW > ACC_W) ? PW : ACC_W) + 3;

    logic signed [EW-1:0]      prev_error_reg;
    logic signed [EW-1:0]      prev_prev_error_reg;
    logic signed [ACC_W-1:0]   integral_acc_reg;
    logic signed [DRIVE_W-1:0] last_drive_reg;

    logic signed [EW-1:0]      prev_error_next;
    logic signed [EW-1:0]      prev_prev_error_next;
    logic signed [ACC_W-1:0]   integral_acc_next;
    logic signed [DRIVE_W-1:0] last_drive_next;

    logic signed [D2W-1:0] err_x;
    logic signed [D2W-1:0] diff1_x;
    logic signed [D2W-1:0] diff2_x;
    logic signed [PW-1:0]  op_p;
    logic signed [PW-1:0]  op_i;
    logic signed [PW-1:0]  op_d;
    logic signed [PW-1:0]  prod_p;
    logic signed [PW-1:0]  prod_i;
    logic signed [PW-1:0]  prod_d;
    logic signed [PW-1:0]  term_p;
    logic signed [PW-1:0]  term_i;
    logic signed [PW-1:0]  term_d;
    logic signed [SW-1:0]  int_sum;
    logic signed [SW-1:0]  int_pos;
    logic signed [SW-1:0]  int_inc;
    logic signed [SW-1:0]  drive_sum;
    logic signed [SW-1:0]  drive_sat;

    // Symmetric clamp to +-lim
    function automatic logic signed [SW-1:0] clamp_sym(
        input logic signed [SW-1:0] v,
        input logic [LIMIT_W-1:0]   lim
    );
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] res;
        hi = $signed(SW'(lim));
        priority if (v > hi)
            res = hi;
        else if (v < -hi)
            res = -hi;
        else
            res = v;
        return res;
    endfunction

    // Saturate to the 32-bit signed range
    function automatic logic signed [SW-1:0] sat_acc(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] res;
        hi = $signed(SW'({1'b0, {(ACC_W-1){1'b1}}}));
        priority if (v > hi)
            res = hi;
        else if (v < ~hi)
            res = ~hi;
        else
            res = v;
        return res;
    endfunction

    // Error e = setpoint - measured and its first and second differences
    always_comb
    begin
        err_x   = D2W'(setpoint) - D2W'(measured);
        diff1_x = err_x - D2W'(prev_error_reg);
        diff2_x = diff1_x - D2W'(prev_error_reg) + D2W'(prev_prev_error_reg);
    end

    // Multiplier operands follow the mode
    always_comb
    begin
        op_i = PW'(err_x);
        if (settings.mode_incremental == MODE_INCREMENTAL)
        begin
            op_p = PW'(diff1_x);
            op_d = PW'(diff2_x);
        end
        else
        begin
            op_p = PW'(err_x);
            op_d = PW'(diff1_x);
        end
    end

    // Three gain products, each shifted toward minus infinity
    assign prod_p = PW'(settings.kp) * op_p;
    assign prod_i = PW'(settings.ki) * op_i;
    assign prod_d = PW'(settings.kd) * op_d;
    assign term_p = prod_p >>> settings.frac_shift;
    assign term_i = prod_i >>> settings.frac_shift;
    assign term_d = prod_d >>> settings.frac_shift;

    // Integral: clamped accumulate, or the saturated increment alone
    assign int_sum = SW'(integral_acc_reg) + SW'(term_i);
    assign int_pos = clamp_sym(int_sum, settings.integral_limit);
    assign int_inc = sat_acc(SW'(term_i));

    // Output sum and clamp
    always_comb
    begin
        if (settings.mode_incremental == MODE_INCREMENTAL)
            drive_sum = SW'(last_drive_reg) + SW'(term_p) + SW'(term_i) + SW'(term_d);
        else
            drive_sum = SW'(term_p) + int_pos + SW'(term_d);
        drive_sat = clamp_sym(drive_sum, settings.out_limit);
    end

    // History update, cleared by a clear request
    always_comb
    begin
        if (req_type == REQ_CLEAR)
        begin
            prev_error_next      = '0;
            prev_prev_error_next = '0;
            integral_acc_next    = '0;
            last_drive_next      = '0;
        end
        else
        begin
            prev_error_next      = err_x[EW-1:0];
            prev_prev_error_next = prev_error_reg;
            if (settings.mode_incremental == MODE_INCREMENTAL)
                integral_acc_next = int_inc[ACC_W-1:0];
            else
                integral_acc_next = int_pos[ACC_W-1:0];
            last_drive_next      = drive_sat[DRIVE_W-1:0];
        end
    end

    assign drive_next = last_drive_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
            integral_acc_reg    <= '0;
            last_drive_reg      <= '0;
        end
        else if (step_en)
        begin
            prev_error_reg      <= prev_error_next;
            prev_prev_error_reg <= prev_prev_error_next;
            integral_acc_reg    <= integral_acc_next;
            last_drive_reg      <= last_drive_next;
        end
    end

endmodule
